// ===== hdl/bwa_pkg.sv =====
package bwa_pkg;

  // register file geometry
  localparam int RegCount = 8;
  localparam int RegIdxW  = $clog2(RegCount);

  // condition code bit positions
  localparam int FlagC = 0;
  localparam int FlagV = 1;
  localparam int FlagZ = 2;
  localparam int FlagN = 3;
  localparam int FlagH = 5;

  // request opcodes as they arrive on the input channel
  typedef enum logic [4:0] {
    REQ_MOVB = 5'd0,
    REQ_MOVW = 5'd1,
    REQ_ADDB = 5'd2,
    REQ_ADDW = 5'd3,
    REQ_ADDS = 5'd4,
    REQ_ADDX = 5'd5,
    REQ_CMPB = 5'd6,
    REQ_CMPW = 5'd7,
    REQ_SUBB = 5'd8,
    REQ_SUBW = 5'd9,
    REQ_SUBX = 5'd10,
    REQ_SUBS = 5'd11,
    REQ_OR   = 5'd12,
    REQ_XOR  = 5'd13,
    REQ_AND  = 5'd14,
    REQ_NOP  = 5'd15,
    REQ_STC  = 5'd16
  } req_e;

  // operation classes seen by the execute side
  typedef enum logic [3:0] {
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_CMP,
    OP_ADDS,
    OP_SUBS,
    OP_OR,
    OP_XOR,
    OP_AND,
    OP_NOP,
    OP_STC,
    OP_UNS
  } op_e;

  // decoded instruction held in the issue queue
  typedef struct packed {
    op_e                op;
    logic               word;
    logic               use_carry;
    logic               sticky_z;
    logic               src_is_imm;
    logic [RegIdxW-1:0] src_idx;
    logic               src_lo;
    logic [RegIdxW-1:0] dst_idx;
    logic               dst_lo;
    logic [15:0]        imm;
  } uop_t;

  // one result beat
  typedef struct packed {
    logic [15:0] result_value;
    logic [7:0]  flags_out;
    logic        reg_written;
    logic        unsupported;
  } rsp_t;

  // queue handshake between front and back
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

// ===== hdl/bwa_if.sv =====
interface bwa_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  req_type;
  logic        src_is_imm;
  logic [3:0]  src_reg;
  logic [3:0]  dst_reg;
  logic [15:0] imm_value;

  modport source (
    output valid, req_type, src_is_imm, src_reg, dst_reg, imm_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, src_is_imm, src_reg, dst_reg, imm_value,
    output ready
  );
endinterface

interface bwa_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_value;
  logic [7:0]  flags_out;
  logic        reg_written;
  logic        unsupported;

  modport source (
    output valid, result_value, flags_out, reg_written, unsupported,
    input  ready
  );
  modport sink (
    input  valid, result_value, flags_out, reg_written, unsupported,
    output ready
  );
endinterface

// ===== hdl/bwa_ram.sv =====
module bwa_ram #(
  parameter int Width = 16,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports, old data on a same-edge write
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hdl/bwa_queue.sv =====
module bwa_queue
  import bwa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  uop_t    push_data_i,
  input  logic    pop_i,
  output uop_t    head_o,
  output q_stat_t stat_o
);

  uop_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign stat_o.valid = (cnt_q != 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);
  assign head_o       = slot_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && stat_o.valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/bwa_front.sv =====
module bwa_front
  import bwa_pkg::*;
(
  bwa_req_if.sink req_i,
  input  q_stat_t stat_i,
  output logic    push_o,
  output uop_t    uop_o
);

  logic imm;

  assign imm         = req_i.src_is_imm;
  assign req_i.ready = !stat_i.full;
  assign push_o      = req_i.valid && !stat_i.full;

  // classify the request and check the source form
  always_comb begin
    uop_o            = '0;
    uop_o.src_is_imm = imm;
    uop_o.src_idx    = req_i.src_reg[RegIdxW-1:0];
    uop_o.src_lo     = req_i.src_reg[3];
    uop_o.dst_idx    = req_i.dst_reg[RegIdxW-1:0];
    uop_o.dst_lo     = req_i.dst_reg[3];
    uop_o.imm        = req_i.imm_value;
    uop_o.op         = OP_UNS;
    unique case (req_i.req_type)
      REQ_MOVB: uop_o.op = OP_MOV;
      REQ_MOVW: begin
        uop_o.op   = OP_MOV;
        uop_o.word = 1'b1;
      end
      REQ_ADDB: uop_o.op = OP_ADD;
      REQ_ADDW: begin
        uop_o.op   = imm ? OP_UNS : OP_ADD;
        uop_o.word = 1'b1;
      end
      REQ_ADDS: begin
        uop_o.op   = imm ? OP_ADDS : OP_UNS;
        uop_o.word = 1'b1;
      end
      REQ_ADDX: begin
        uop_o.op        = OP_ADD;
        uop_o.use_carry = 1'b1;
      end
      REQ_CMPB: uop_o.op = OP_CMP;
      REQ_CMPW: begin
        uop_o.op   = imm ? OP_UNS : OP_CMP;
        uop_o.word = 1'b1;
      end
      REQ_SUBB: uop_o.op = imm ? OP_UNS : OP_SUB;
      REQ_SUBW: begin
        uop_o.op   = imm ? OP_UNS : OP_SUB;
        uop_o.word = 1'b1;
      end
      REQ_SUBX: begin
        uop_o.op        = OP_SUB;
        uop_o.use_carry = 1'b1;
        uop_o.sticky_z  = 1'b1;
      end
      REQ_SUBS: begin
        uop_o.op   = imm ? OP_SUBS : OP_UNS;
        uop_o.word = 1'b1;
      end
      REQ_OR:   uop_o.op = OP_OR;
      REQ_XOR:  uop_o.op = OP_XOR;
      REQ_AND:  uop_o.op = OP_AND;
      REQ_NOP:  uop_o.op = OP_NOP;
      REQ_STC:  uop_o.op = OP_STC;
      default:  uop_o.op = OP_UNS;
    endcase
  end

endmodule

// ===== hdl/bwa_back.sv =====
module bwa_back
  import bwa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_stat_t stat_i,
  input  uop_t    head_i,
  output logic    pop_o,
  bwa_rsp_if.source rsp_o
);

  // issue / execute registers
  logic               ex_valid_q;
  uop_t               ex_q;
  logic               issue;
  logic               out_pop;
  logic [2:0]         occ;

  // register file, valid bits and last-write bypass
  logic [15:0]        rd_src, rd_dst;
  logic [RegCount-1:0] vld_q, vld_d;
  logic               lw_valid_q;
  logic [RegIdxW-1:0] lw_idx_q;
  logic [15:0]        lw_data_q;

  // condition codes
  logic [7:0]         ccr_q, ccr_d;

  // execute datapath
  logic [15:0] src_word, dst_word, src_val, dst_val, sb, db;
  logic [15:0] op_a, op_b, res, wr_word;
  logic        cin, sub, wr_en;
  logic [16:0] sum;
  logic [12:0] lo_a, lo_b, low;
  logic        h_f, n_f, z_f, v_f, c_f;
  logic        top_a, top_b, top_r;
  rsp_t        ex_rsp;

  // output buffer
  rsp_t        ob_q [2];
  logic        ob_wr_q, ob_rd_q;
  logic [1:0]  ob_cnt_q, ob_cnt_d;

  // issue only when the output buffer has room for everything in flight
  assign out_pop = rsp_o.valid && rsp_o.ready;
  assign occ     = {1'b0, ob_cnt_q} + {2'b0, ex_valid_q} - {2'b0, out_pop};
  assign issue   = stat_i.valid && (occ < 3'd2);
  assign pop_o   = issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else begin
      ex_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      ex_q <= head_i;
    end
  end

  bwa_ram #(
    .Width (16),
    .Depth (RegCount)
  ) u_rf (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (ex_q.dst_idx),
    .wdata_i   (wr_word),
    .raddr_a_i (head_i.src_idx),
    .raddr_b_i (head_i.dst_idx),
    .rdata_a_o (rd_src),
    .rdata_b_o (rd_dst)
  );

  // operand fetch with bypass of the most recent write
  always_comb begin
    if (lw_valid_q && (lw_idx_q == ex_q.src_idx)) begin
      src_word = lw_data_q;
    end else begin
      src_word = vld_q[ex_q.src_idx] ? rd_src : 16'h0000;
    end
    if (lw_valid_q && (lw_idx_q == ex_q.dst_idx)) begin
      dst_word = lw_data_q;
    end else begin
      dst_word = vld_q[ex_q.dst_idx] ? rd_dst : 16'h0000;
    end
  end

  // operand selection: byte halves and immediate
  always_comb begin
    sb      = ex_q.src_is_imm ? {8'h00, ex_q.imm[7:0]}
            : (ex_q.src_lo ? {8'h00, src_word[7:0]} : {8'h00, src_word[15:8]});
    db      = ex_q.dst_lo ? {8'h00, dst_word[7:0]} : {8'h00, dst_word[15:8]};
    src_val = ex_q.word ? (ex_q.src_is_imm ? ex_q.imm : src_word) : sb;
    dst_val = ex_q.word ? dst_word : db;
  end

  // add / subtract with half carry
  always_comb begin
    sub  = (ex_q.op == OP_SUB) || (ex_q.op == OP_CMP);
    op_a = sub ? dst_val : src_val;
    op_b = sub ? src_val : dst_val;
    cin  = ex_q.use_carry & ccr_q[FlagC];
    lo_a = ex_q.word ? {1'b0, op_a[11:0]} : {9'h000, op_a[3:0]};
    lo_b = ex_q.word ? {1'b0, op_b[11:0]} : {9'h000, op_b[3:0]};
    if (sub) begin
      sum = {1'b0, op_a} - {1'b0, op_b} - {16'h0000, cin};
      low = lo_a - lo_b - {12'h000, cin};
    end else begin
      sum = {1'b0, op_a} + {1'b0, op_b} + {16'h0000, cin};
      low = lo_a + lo_b + {12'h000, cin};
    end
    top_a = ex_q.word ? op_a[15] : op_a[7];
    top_b = ex_q.word ? op_b[15] : op_b[7];
    top_r = ex_q.word ? sum[15] : sum[7];
    h_f   = ex_q.word ? low[12] : low[4];
    c_f   = ex_q.word ? sum[16] : sum[8];
    n_f   = top_r;
    z_f   = ex_q.word ? (sum[15:0] == 16'h0000) : (sum[7:0] == 8'h00);
    if (ex_q.sticky_z) begin
      z_f = z_f & ccr_q[FlagZ];
    end
    if (sub) begin
      v_f = (top_a ^ top_b) & (top_a ^ top_r);
    end else begin
      v_f = ~(top_a ^ top_b) & (top_a ^ top_r);
    end
  end

  // result, writeback and flag update per operation
  always_comb begin
    res   = 16'h0000;
    wr_en = 1'b0;
    ccr_d = ccr_q;
    case (ex_q.op)
      OP_MOV: begin
        res          = src_val;
        wr_en        = 1'b1;
        ccr_d[FlagN] = ex_q.word ? res[15] : res[7];
        ccr_d[FlagZ] = ex_q.word ? (res == 16'h0000) : (res[7:0] == 8'h00);
        ccr_d[FlagV] = 1'b0;
      end
      OP_ADD, OP_SUB, OP_CMP: begin
        res          = ex_q.word ? sum[15:0] : {8'h00, sum[7:0]};
        wr_en        = (ex_q.op != OP_CMP);
        ccr_d[FlagH] = h_f;
        ccr_d[FlagN] = n_f;
        ccr_d[FlagZ] = z_f;
        ccr_d[FlagV] = v_f;
        ccr_d[FlagC] = c_f;
      end
      OP_ADDS: begin
        res   = dst_word + ex_q.imm;
        wr_en = 1'b1;
      end
      OP_SUBS: begin
        res   = dst_word - ex_q.imm;
        wr_en = 1'b1;
      end
      OP_OR, OP_XOR, OP_AND: begin
        if (ex_q.op == OP_OR) begin
          res = db | sb;
        end else if (ex_q.op == OP_XOR) begin
          res = db ^ sb;
        end else begin
          res = db & sb;
        end
        wr_en        = 1'b1;
        ccr_d[FlagN] = res[7];
        ccr_d[FlagZ] = (res[7:0] == 8'h00);
        ccr_d[FlagV] = 1'b0;
      end
      OP_STC: begin
        res   = {8'h00, ccr_q};
        wr_en = 1'b1;
      end
      default: begin
        res   = 16'h0000;
        wr_en = 1'b0;
      end
    endcase
    wr_en = wr_en & ex_valid_q;
    if (!ex_valid_q) begin
      ccr_d = ccr_q;
    end
    if (ex_q.word) begin
      wr_word = res;
    end else if (ex_q.dst_lo) begin
      wr_word = {dst_word[15:8], res[7:0]};
    end else begin
      wr_word = {res[7:0], dst_word[7:0]};
    end
  end

  assign ex_rsp.result_value = res;
  assign ex_rsp.flags_out    = ccr_d;
  assign ex_rsp.reg_written  = (ex_q.op != OP_CMP) && (ex_q.op != OP_NOP)
                             && (ex_q.op != OP_UNS);
  assign ex_rsp.unsupported  = (ex_q.op == OP_UNS);

  // register valid bits: an entry never written reads as zero
  always_comb begin
    vld_d = vld_q;
    if (wr_en) begin
      vld_d[ex_q.dst_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      ccr_q      <= 8'h00;
      lw_valid_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      ccr_q <= ccr_d;
      if (wr_en) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lw_idx_q  <= ex_q.dst_idx;
      lw_data_q <= wr_word;
    end
  end

  // two-entry output buffer
  assign ob_cnt_d = ob_cnt_q + {1'b0, ex_valid_q} - {1'b0, out_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= 1'b0;
      ob_rd_q  <= 1'b0;
      ob_cnt_q <= 2'd0;
    end else begin
      ob_wr_q  <= ob_wr_q ^ ex_valid_q;
      ob_rd_q  <= ob_rd_q ^ out_pop;
      ob_cnt_q <= ob_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_valid_q) begin
      ob_q[ob_wr_q] <= ex_rsp;
    end
  end

  assign rsp_o.valid        = (ob_cnt_q != 2'd0);
  assign rsp_o.result_value = ob_q[ob_rd_q].result_value;
  assign rsp_o.flags_out    = ob_q[ob_rd_q].flags_out;
  assign rsp_o.reg_written  = ob_q[ob_rd_q].reg_written;
  assign rsp_o.unsupported  = ob_q[ob_rd_q].unsupported;

endmodule

// ===== hdl/byte_word_alu_with_flags_core.sv =====
// Byte/word ALU with condition codes: executes one decoded instruction per beat
// (mov, add, addx, adds, sub, subx, subs, cmp, or, xor, and, nop, stc) against
// eight 16-bit registers and an 8-bit I6H4NZVC register, and returns one result
// beat per request. Sustained rate is one instruction per clock while rsp_o
// keeps taking results; a request passes through the decode queue, then the
// registered register-file read and execute, then the output buffer, before
// its result is valid on rsp_o.
// Requests are decoded into a two-entry queue, and results wait in a
// two-entry output buffer, so a stall on either side is absorbed until they fill.
// Registers and flags read as zero after reset.
module byte_word_alu_with_flags_core
  import bwa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  bwa_req_if.sink   req_i,
  bwa_rsp_if.source rsp_o
);

  q_stat_t q_stat;
  uop_t    push_uop;
  uop_t    head_uop;
  logic    push;
  logic    pop;

  bwa_front u_front (
    .req_i  (req_i),
    .stat_i (q_stat),
    .push_o (push),
    .uop_o  (push_uop)
  );

  bwa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_uop),
    .pop_i       (pop),
    .head_o      (head_uop),
    .stat_o      (q_stat)
  );

  bwa_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (q_stat),
    .head_i (head_uop),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

endmodule
